FILE: hdl/gmp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmp_pkg
// Shared constants, types and arithmetic helpers for the grid max-path block.
// ----------------------------------------------------------------------------
package gmp_pkg;

   localparam int MAX_COLS_DEF    = 1024;
   localparam int SKIP_LAYERS_DEF = 3;

   localparam int CFG_W   = 11;
   localparam int VALUE_W = 16;
   localparam int AMT_W   = 32;

   localparam logic signed [AMT_W-1:0] UNREACH = -32'sd1000000000;
   localparam logic signed [AMT_W-1:0] AMT_MAX = {1'b0, {(AMT_W-1){1'b1}}};
   localparam logic signed [AMT_W-1:0] AMT_MIN = {1'b1, {(AMT_W-1){1'b0}}};

   typedef struct packed {
      logic                      has_up;
      logic                      has_left;
      logic                      last_cell;
      logic                      fwd;
      logic signed [VALUE_W-1:0] cell_value;
   } gmp_issue_type;

   function automatic logic signed [AMT_W-1:0] sat_add(
      input logic signed [AMT_W-1:0]   a,
      input logic signed [VALUE_W-1:0] b
   );
      logic [AMT_W:0] s;
      s = {a[AMT_W-1], a} + {{(AMT_W+1-VALUE_W){b[VALUE_W-1]}}, b};
      if (s[AMT_W] != s[AMT_W-1]) begin
         return s[AMT_W] ? AMT_MIN : AMT_MAX;
      end
      return $signed(s[AMT_W-1:0]);
   endfunction

   function automatic logic signed [AMT_W-1:0] max_amt(
      input logic signed [AMT_W-1:0] a,
      input logic signed [AMT_W-1:0] b
   );
      return (a > b) ? a : b;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/gmp_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmp_req_if
// Cell input channel: one grid cell per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gmp_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [gmp_pkg::VALUE_W-1:0] cell_value;
   logic                               last_cell;

   modport source (output valid, output cell_value, output last_cell, input ready);
   modport sink   (input valid, input cell_value, input last_cell, output ready);
endinterface
`default_nettype wire

FILE: hdl/gmp_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmp_rsp_if
// Result channel: one best path amount per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gmp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [gmp_pkg::AMT_W-1:0] best_amount;

   modport source (output valid, output best_amount, input ready);
   modport sink   (input valid, input best_amount, output ready);
endinterface
`default_nettype wire

FILE: hdl/gmp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmp_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module gmp_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hdl/gmp_pos.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmp_pos
// Input side: column register, row/column tracking, line-store read issue
// and the issue stage register that lines up with the RAM read data.
// ----------------------------------------------------------------------------
module gmp_pos #(
   parameter  int MAX_COLS = gmp_pkg::MAX_COLS_DEF,
   localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   gmp_req_if.sink                          req_ch,
   input  wire logic                        csr_wr_en,
   input  wire logic [gmp_pkg::CFG_W-1:0]   csr_wr_data,
   input  wire logic                        adv,
   output logic                             s1_valid,
   output gmp_pkg::gmp_issue_type           s1_info,
   output logic      [COL_W-1:0]            s1_col,
   output logic                             rd_en,
   output logic      [COL_W-1:0]            rd_addr
);
   import gmp_pkg::*;

   localparam int CNT_W = ((COL_W + 1) > CFG_W) ? (COL_W + 1) : CFG_W;

   logic [CFG_W-1:0]  grid_cols_ff, grid_cols_in;
   logic [COL_W-1:0]  col_idx_ff, col_idx_in;
   logic              first_row_ff, first_row_in;
   logic              s1_valid_ff, s1_valid_in;
   gmp_issue_type     s1_info_ff, s1_info_in;
   logic [COL_W-1:0]  s1_col_ff, s1_col_in;

   logic [CNT_W-1:0]  cols_raw;
   logic [CNT_W-1:0]  cols_eff;
   logic [CNT_W-1:0]  col_nxt;
   logic [COL_W-1:0]  col_cur;
   logic              wrap;
   logic              accept;
   logic              has_up;

   assign accept       = req_ch.valid && adv;
   assign req_ch.ready = adv;

   always_comb begin
      cols_raw = CNT_W'(grid_cols_ff);
      if (cols_raw == '0) begin
         cols_eff = CNT_W'(1);
      end else if (cols_raw > CNT_W'(MAX_COLS)) begin
         cols_eff = CNT_W'(MAX_COLS);
      end else begin
         cols_eff = cols_raw;
      end

      // stale index from a wider setting maps to the last column
      if (CNT_W'(col_idx_ff) >= cols_eff) begin
         col_cur = COL_W'(cols_eff - CNT_W'(1));
      end else begin
         col_cur = col_idx_ff;
      end
      col_nxt = CNT_W'(col_cur) + CNT_W'(1);
      wrap    = col_nxt >= cols_eff;
      has_up  = !first_row_ff;

      grid_cols_in = csr_wr_en ? csr_wr_data : grid_cols_ff;
      col_idx_in   = col_idx_ff;
      first_row_in = first_row_ff;
      if (accept) begin
         if (req_ch.last_cell) begin
            col_idx_in   = '0;
            first_row_in = 1'b1;
         end else if (wrap) begin
            col_idx_in   = '0;
            first_row_in = 1'b0;
         end else begin
            col_idx_in   = COL_W'(col_nxt);
         end
      end

      s1_valid_in = s1_valid_ff;
      s1_info_in  = s1_info_ff;
      s1_col_in   = s1_col_ff;
      if (adv) begin
         s1_valid_in = accept;
      end
      if (accept) begin
         s1_info_in.has_up     = has_up;
         s1_info_in.has_left   = col_cur != '0;
         s1_info_in.last_cell  = req_ch.last_cell;
         s1_info_in.cell_value = req_ch.cell_value;
         // same column being written back this edge: take it from stage 2
         s1_info_in.fwd        = s1_valid_ff && (s1_col_ff == col_cur) && has_up;
         s1_col_in             = col_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= CFG_W'(1);
         col_idx_ff   <= '0;
         first_row_ff <= 1'b1;
         s1_valid_ff  <= 1'b0;
      end else begin
         grid_cols_ff <= grid_cols_in;
         col_idx_ff   <= col_idx_in;
         first_row_ff <= first_row_in;
         s1_valid_ff  <= s1_valid_in;
      end
      s1_info_ff <= s1_info_in;
      s1_col_ff  <= s1_col_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1_info  = s1_info_ff;
   assign s1_col   = s1_col_ff;
   assign rd_en    = accept;
   assign rd_addr  = col_cur;

`ifndef SYNTHESIS
   a_grid_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.last_cell |=> col_idx_ff == '0 && first_row_ff)
      else $error("position not restarted after last cell");

   a_issue_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !adv |=> s1_valid_ff && $stable(s1_col_ff) && $stable(s1_info_ff))
      else $error("issue stage changed while stalled");
`endif

endmodule
`default_nettype wire

FILE: hdl/gmp_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmp_dp
// Cell update: per-layer best over up/left neighbors, line-store write-back,
// left-neighbor register, result reduction and output register.
// ----------------------------------------------------------------------------
module gmp_dp #(
   parameter  int MAX_COLS    = gmp_pkg::MAX_COLS_DEF,
   parameter  int SKIP_LAYERS = gmp_pkg::SKIP_LAYERS_DEF,
   localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
   localparam int ROW_W       = SKIP_LAYERS * gmp_pkg::AMT_W
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   s1_valid,
   input  wire gmp_pkg::gmp_issue_type s1_info,
   input  wire logic [COL_W-1:0]       s1_col,
   input  wire logic [ROW_W-1:0]       rd_data,
   output logic                        adv,
   output logic                        wr_en,
   output logic      [COL_W-1:0]       wr_addr,
   output logic      [ROW_W-1:0]       wr_data,
   gmp_rsp_if.source                   rsp_ch
);
   import gmp_pkg::*;

   typedef logic [SKIP_LAYERS-1:0][AMT_W-1:0] row_type;

   row_type                  up_row;
   row_type                  cur_row;
   row_type                  left_ff;
   row_type                  s2_cur_ff;
   logic                     s2_valid_ff, s2_valid_in;
   logic                     s2_last_ff, s2_last_in;
   logic                     out_valid_ff, out_valid_in;
   logic signed [AMT_W-1:0]  best_ff, best_in;
   logic                     out_load;
   logic                     step;

   assign adv     = !(s2_valid_ff && s2_last_ff && out_valid_ff && !rsp_ch.ready);
   assign step    = s1_valid && adv;
   assign up_row  = s1_info.fwd ? s2_cur_ff : row_type'(rd_data);

   always_comb begin
      logic signed [AMT_W-1:0] best;
      cur_row = '0;
      for (int k = 0; k < SKIP_LAYERS; k++) begin
         if (!s1_info.has_up && !s1_info.has_left) begin
            best = (k == 0) ? AMT_W'(s1_info.cell_value) : '0;
         end else begin
            best = UNREACH;
            if (s1_info.has_up) begin
               best = max_amt(best, sat_add(up_row[k], s1_info.cell_value));
               if (k > 0) begin
                  best = max_amt(best, up_row[(k > 0) ? k - 1 : 0]);
               end
            end
            if (s1_info.has_left) begin
               best = max_amt(best, sat_add(left_ff[k], s1_info.cell_value));
               if (k > 0) begin
                  best = max_amt(best, left_ff[(k > 0) ? k - 1 : 0]);
               end
            end
         end
         cur_row[k] = best;
      end
   end

   always_comb begin
      best_in = s2_cur_ff[0];
      for (int k = 1; k < SKIP_LAYERS; k++) begin
         best_in = max_amt(best_in, s2_cur_ff[k]);
      end
   end

   always_comb begin
      out_load     = s2_valid_ff && s2_last_ff && (!out_valid_ff || rsp_ch.ready);
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      s2_last_in  = s2_last_ff;
      if (adv) begin
         s2_valid_in = s1_valid;
         s2_last_in  = s1_info.last_cell;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s2_last_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         s2_last_ff   <= s2_last_in;
         out_valid_ff <= out_valid_in;
      end
      if (step) begin
         left_ff   <= cur_row;
         s2_cur_ff <= cur_row;
      end
      if (out_load) begin
         best_ff <= best_in;
      end
   end

   assign wr_en              = step;
   assign wr_addr            = s1_col;
   assign wr_data            = ROW_W'(cur_row);
   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.best_amount = best_ff;

`ifndef SYNTHESIS
   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_last_ff && !adv |=> s2_valid_ff && s2_last_ff)
      else $error("blocked result dropped from stage 2");

   a_last_reaches_s2: assert property (@(posedge clock) disable iff (reset)
      step && s1_info.last_cell |=> s2_valid_ff && s2_last_ff)
      else $error("last cell lost between stages");
`endif

endmodule
`default_nettype wire

FILE: hdl/grid_max_path_with_skips.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_max_path_with_skips
// Streaming max path sum over a grid, right/down moves, up to two skips.
//
// req_ch carries one grid cell per word in row-major order: cell_value and
// last_cell, which marks the bottom-right cell. rsp_ch carries one word per
// grid, best_amount, the best path sum over zero, one or two skipped cells.
// csr_wr_en/csr_wr_data set the column count; write it only while idle.
// Out-of-range counts are clamped to 1..MAX_COLS.
//
// Throughput is one cell per cycle while req_ch.ready is high. Each cell does
// one line-store read and one write-back in a single-port-per-direction RAM
// holding all skip layers of a column in one word; a same-column hit between
// neighbors is forwarded. The last cell's result is registered in stage 2
// (cell update from the line-store read), then reduced into the output reg.
//
// Reset clears position, pipeline and output state and sets the column
// count to 1; the line store is not cleared. While a result waits on a
// stalled receiver, cells keep flowing until the next last cell reaches the
// reduction stage; only then does req_ch.ready drop.
// ----------------------------------------------------------------------------
module grid_max_path_with_skips #(
   parameter int MAX_COLS    = gmp_pkg::MAX_COLS_DEF,
   parameter int SKIP_LAYERS = gmp_pkg::SKIP_LAYERS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   gmp_req_if.sink                        req_ch,
   gmp_rsp_if.source                      rsp_ch,
   input  wire logic                      csr_wr_en,
   input  wire logic [gmp_pkg::CFG_W-1:0] csr_wr_data
);
   import gmp_pkg::*;

   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W = SKIP_LAYERS * AMT_W;

   logic              adv;
   logic              s1_valid;
   gmp_issue_type     s1_info;
   logic [COL_W-1:0]  s1_col;
   logic              rd_en;
   logic [COL_W-1:0]  rd_addr;
   logic [ROW_W-1:0]  rd_data;
   logic              wr_en;
   logic [COL_W-1:0]  wr_addr;
   logic [ROW_W-1:0]  wr_data;

   gmp_pos #(
      .MAX_COLS (MAX_COLS)
   ) u_pos (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .adv         (adv),
      .s1_valid    (s1_valid),
      .s1_info     (s1_info),
      .s1_col      (s1_col),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr)
   );

   gmp_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_COLS)
   ) u_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gmp_dp #(
      .MAX_COLS    (MAX_COLS),
      .SKIP_LAYERS (SKIP_LAYERS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1_info  (s1_info),
      .s1_col   (s1_col),
      .rd_data  (rd_data),
      .adv      (adv),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rsp_ch   (rsp_ch)
   );

endmodule
`default_nettype wire
